// ===== src/irpfd_pkg.sv =====
// Shared types, constants and helpers of the IR pulse frame decoder.
package irpfd_pkg;

  // Frame geometry: bits per frame and where the data code ends.
  localparam int FRAME_BITS = 32;
  localparam int CODE_SPLIT = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

  localparam int CFG_IDX_W = 4;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_HIGH_MIN = 4'd0,
    REG_LEAD_HIGH_MAX = 4'd1,
    REG_LEAD_LOW_MIN  = 4'd2,
    REG_LEAD_LOW_MAX  = 4'd3,
    REG_ONE_MIN       = 4'd4,
    REG_ONE_MAX       = 4'd5,
    REG_ZERO_MIN      = 4'd6,
    REG_ZERO_MAX      = 4'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_LEAD_HIGH_MIN = 16'd12000;
  localparam logic [15:0] RST_LEAD_HIGH_MAX = 16'd15000;
  localparam logic [15:0] RST_LEAD_LOW_MIN  = 16'd1500;
  localparam logic [15:0] RST_LEAD_LOW_MAX  = 16'd2100;
  localparam logic [15:0] RST_ONE_MIN       = 16'd2000;
  localparam logic [15:0] RST_ONE_MAX       = 16'd2600;
  localparam logic [15:0] RST_ZERO_MIN      = 16'd800;
  localparam logic [15:0] RST_ZERO_MAX      = 16'd1400;

  // Remote codes recognised by the fan logic.
  localparam logic [15:0] USER_FAN  = 16'h00ff;
  localparam logic [15:0] KEY_POWER = 16'h8877;
  localparam logic [15:0] KEY_SWING = 16'h6897;
  localparam logic [15:0] KEY_UP    = 16'h48b7;
  localparam logic [15:0] KEY_DOWN  = 16'ha857;

  localparam logic [2:0] BEEP_SHORT = 3'd1;
  localparam logic [2:0] BEEP_LONG  = 3'd5;
  localparam logic [1:0] REP_ONE    = 2'd1;
  localparam logic [1:0] REP_TWO    = 2'd2;
  localparam logic [1:0] FAN_OFF    = 2'd0;
  localparam logic [1:0] FAN_MIN    = 2'd1;
  localparam logic [1:0] FAN_MAX    = 2'd3;

  // Class of one capture as seen by the front end.
  typedef enum logic [1:0] {
    CLS_LEAD = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_ZERO = 2'd2,
    CLS_BAD  = 2'd3
  } cls_t;

  typedef struct packed {
    logic [15:0] lead_high_min;
    logic [15:0] lead_high_max;
    logic [15:0] lead_low_min;
    logic [15:0] lead_low_max;
    logic [15:0] one_min;
    logic [15:0] one_max;
    logic [15:0] zero_min;
    logic [15:0] zero_max;
  } win_cfg_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_error;
    logic [15:0] addr_code;
    logic [15:0] cmd_code;
    logic [1:0]  speed_level;
    logic        oscillate_on;
    logic        speed_lamp;
    logic        oscillate_lamp;
    logic        beep_valid;
    logic [2:0]  beep_length;
    logic [1:0]  beep_repeat;
  } result_t;

  // Inclusive window test; an inverted window never matches.
  function automatic logic in_window(input logic [15:0] v, input logic [15:0] lo,
                                     input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ===== src/irpfd_classify.sv =====
// Front end: window registers and classification of each timer capture.
module irpfd_classify import irpfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [15:0]          high_count,
  input  logic [15:0]          period_count,
  output cls_t                 cls
);

  win_cfg_t    win;
  logic [15:0] low_count;
  logic        is_lead;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.lead_high_min <= RST_LEAD_HIGH_MIN;
      win.lead_high_max <= RST_LEAD_HIGH_MAX;
      win.lead_low_min  <= RST_LEAD_LOW_MIN;
      win.lead_low_max  <= RST_LEAD_LOW_MAX;
      win.one_min       <= RST_ONE_MIN;
      win.one_max       <= RST_ONE_MAX;
      win.zero_min      <= RST_ZERO_MIN;
      win.zero_max      <= RST_ZERO_MAX;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEAD_HIGH_MIN: win.lead_high_min <= cfg_data;
        REG_LEAD_HIGH_MAX: win.lead_high_max <= cfg_data;
        REG_LEAD_LOW_MIN:  win.lead_low_min  <= cfg_data;
        REG_LEAD_LOW_MAX:  win.lead_low_max  <= cfg_data;
        REG_ONE_MIN:       win.one_min       <= cfg_data;
        REG_ONE_MAX:       win.one_max       <= cfg_data;
        REG_ZERO_MIN:      win.zero_min      <= cfg_data;
        REG_ZERO_MAX:      win.zero_max      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The low time wraps modulo 2^16, like the capture counters themselves.
  assign low_count = period_count - high_count;
  assign is_lead   = in_window(high_count, win.lead_high_min, win.lead_high_max) &&
                     in_window(low_count, win.lead_low_min, win.lead_low_max);

  // Lead wins over a bit reading, and a one wins over a zero.
  always_comb begin
    if (is_lead) begin
      cls = CLS_LEAD;
    end else if (in_window(high_count, win.one_min, win.one_max)) begin
      cls = CLS_ONE;
    end else if (in_window(high_count, win.zero_min, win.zero_max)) begin
      cls = CLS_ZERO;
    end else begin
      cls = CLS_BAD;
    end
  end

endmodule

// ===== src/irpfd_evt_queue.sv =====
// Two-entry queue of classified captures between front end and frame engine.
module irpfd_evt_queue import irpfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_cls,
  output logic full,
  input  logic pop,
  output logic valid,
  output cls_t head
);

  cls_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cls;
    end
  end

  a_evt_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("event queue holds more than two entries");

endmodule

// ===== src/irpfd_result_queue.sv =====
// Two-entry output queue holding finished results until they are popped.
module irpfd_result_queue import irpfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    ready,
  input  logic    pop,
  output logic    empty,
  output result_t head
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign empty  = (count == 2'd0);
  assign do_pop = pop && !empty;
  assign ready  = (count != 2'd2) || do_pop;
  assign head   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_res;
    end
  end

  a_res_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("result written into a full output queue");

endmodule

// ===== src/irpfd_frame_engine.sv =====
// Back end: bit collection, frame completion and fan key handling.
module irpfd_frame_engine import irpfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    evt_valid,
  input  cls_t    evt_cls,
  output logic    evt_pop,
  input  logic    res_ready,
  output logic    res_push,
  output result_t res
);

  logic                  collecting;
  logic [CNT_W-1:0]      bit_count;
  logic [FRAME_BITS-1:0] shift_word;
  logic [15:0]           last_addr;
  logic [15:0]           last_cmd;
  logic [1:0]            fan_level;
  logic                  swing_flag;
  logic                  level_lamp;
  logic                  swing_lamp;

  logic                  collecting_next;
  logic [CNT_W-1:0]      bit_count_next;
  logic [FRAME_BITS-1:0] shift_word_next;
  logic [15:0]           last_addr_next;
  logic [15:0]           last_cmd_next;
  logic [1:0]            fan_level_next;
  logic                  swing_flag_next;
  logic                  level_lamp_next;
  logic                  swing_lamp_next;

  logic                  done;
  logic                  err;
  logic                  bval;
  logic [2:0]            blen;
  logic [1:0]            brep;
  logic [FRAME_BITS-1:0] word_in;
  logic [15:0]           addr_new;
  logic [15:0]           cmd_new;

  assign evt_pop  = evt_valid && res_ready;
  assign res_push = evt_pop;

  // Bits arrive MSB first, so shifting left leaves the first bit on top.
  assign word_in  = {shift_word[FRAME_BITS-2:0], (evt_cls == CLS_ONE)};
  assign cmd_new  = word_in[CODE_SPLIT-1:0];
  assign addr_new = 16'(word_in[FRAME_BITS-1:CODE_SPLIT]);

  always_comb begin
    collecting_next = collecting;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    last_addr_next  = last_addr;
    last_cmd_next   = last_cmd;
    fan_level_next  = fan_level;
    swing_flag_next = swing_flag;
    level_lamp_next = level_lamp;
    swing_lamp_next = swing_lamp;
    done            = 1'b0;
    err             = 1'b0;
    bval            = 1'b0;
    blen            = 3'd0;
    brep            = 2'd0;
    if (evt_pop) begin
      case (evt_cls)
        CLS_LEAD: begin
          collecting_next = 1'b1;
          bit_count_next  = '0;
          shift_word_next = '0;
        end
        CLS_BAD: begin
          if (collecting) begin
            collecting_next = 1'b0;
            shift_word_next = '0;
            err             = 1'b1;
          end
        end
        CLS_ONE, CLS_ZERO: begin
          if (collecting && (bit_count == LAST_BIT)) begin
            collecting_next = 1'b0;
            shift_word_next = '0;
            last_addr_next  = addr_new;
            last_cmd_next   = cmd_new;
            done            = 1'b1;
            if (addr_new == USER_FAN) begin
              case (cmd_new)
                KEY_POWER: begin
                  bval = 1'b1;
                  brep = REP_ONE;
                  if (fan_level == FAN_OFF) begin
                    fan_level_next  = FAN_MIN;
                    blen            = BEEP_SHORT;
                    level_lamp_next = 1'b1;
                  end else begin
                    fan_level_next  = FAN_OFF;
                    blen            = BEEP_LONG;
                    level_lamp_next = 1'b0;
                    swing_flag_next = 1'b0;
                    swing_lamp_next = 1'b0;
                  end
                end
                KEY_SWING: begin
                  if (fan_level != FAN_OFF) begin
                    swing_flag_next = !swing_flag;
                    swing_lamp_next = !swing_flag;
                    bval            = 1'b1;
                    blen            = BEEP_SHORT;
                    brep            = swing_flag ? REP_TWO : REP_ONE;
                  end
                end
                KEY_UP, KEY_DOWN: begin
                  if (fan_level != FAN_OFF) begin
                    if ((cmd_new == KEY_UP) && (fan_level != FAN_MAX)) begin
                      fan_level_next = fan_level + 2'd1;
                    end
                    if ((cmd_new == KEY_DOWN) && (fan_level > FAN_MIN)) begin
                      fan_level_next = fan_level - 2'd1;
                    end
                    bval            = 1'b1;
                    blen            = BEEP_SHORT;
                    brep            = REP_ONE;
                    level_lamp_next = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end else if (collecting) begin
            bit_count_next  = bit_count + CNT_W'(1);
            shift_word_next = word_in;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.frame_done     = done;
    res.frame_error    = err;
    res.addr_code      = last_addr_next;
    res.cmd_code       = last_cmd_next;
    res.speed_level    = fan_level_next;
    res.oscillate_on   = swing_flag_next;
    res.speed_lamp     = level_lamp_next;
    res.oscillate_lamp = swing_lamp_next;
    res.beep_valid     = bval;
    res.beep_length    = blen;
    res.beep_repeat    = brep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      bit_count  <= '0;
      shift_word <= '0;
      last_addr  <= '0;
      last_cmd   <= '0;
      fan_level  <= FAN_OFF;
      swing_flag <= 1'b0;
      level_lamp <= 1'b0;
      swing_lamp <= 1'b0;
    end else begin
      collecting <= collecting_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
      last_addr  <= last_addr_next;
      last_cmd   <= last_cmd_next;
      fan_level  <= fan_level_next;
      swing_flag <= swing_flag_next;
      level_lamp <= level_lamp_next;
      swing_lamp <= swing_lamp_next;
    end
  end

  a_lamp_tracks_level : assert property (@(posedge clk) disable iff (rst)
    level_lamp == (fan_level != FAN_OFF))
    else $error("speed lamp disagrees with fan level");

  a_swing_only_when_on : assert property (@(posedge clk) disable iff (rst)
    (swing_lamp == swing_flag) && (!swing_flag || (fan_level != FAN_OFF)))
    else $error("oscillation flag or lamp inconsistent with fan state");

  a_done_returns_idle : assert property (@(posedge clk) disable iff (rst)
    (evt_pop && done) |=> !collecting)
    else $error("engine still collecting after a complete frame");

endmodule

// ===== src/ir_pulse_frame_decoder.sv =====
// Top level of the IR pulse frame decoder with fan key handling.
//
// Each request on the capture side is one timer capture (high time and whole
// period); the low time is taken as the period minus the high time, wrapping
// modulo 2^16. A capture whose high and low times both sit in the lead
// windows starts a new frame; after that each capture's high time is read as
// a one, a zero or an invalid time, which aborts the frame with frame_error.
// Bits are collected most significant first, and after the last bit of the
// frame the low sixteen bits become cmd_code and the upper bits addr_code,
// with frame_done set. Frames addressed to the fan user code drive the power,
// oscillate, speed up and speed down keys and raise a beep request, the last
// three only while the fan is on. Every accepted capture yields exactly one
// result. The block takes one capture per clock cycle while full is low: a
// front end classifies the capture against the window registers in the cycle
// it is accepted, a two-entry queue carries the class to the frame engine,
// which updates the frame and fan state and writes the result into a
// two-entry output queue. A result becomes visible once its class has left
// the event queue and the engine has written it into the output queue; while
// results are not popped, up to four captures are buffered before full rises.
// Window registers are written through the configuration channel, which is
// always ready and ignores indexes beyond the last register; write them only
// while no capture is in flight. There is no clearing pass after reset.
module ir_pulse_frame_decoder import irpfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [15:0]          high_count,
  input  logic [15:0]          period_count,
  output logic                 empty,
  input  logic                 pop,
  output logic                 frame_done,
  output logic                 frame_error,
  output logic [15:0]          addr_code,
  output logic [15:0]          cmd_code,
  output logic [1:0]           speed_level,
  output logic                 oscillate_on,
  output logic                 speed_lamp,
  output logic                 oscillate_lamp,
  output logic                 beep_valid,
  output logic [2:0]           beep_length,
  output logic [1:0]           beep_repeat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cls_t    front_cls;
  cls_t    evt_head;
  logic    evt_valid;
  logic    evt_pop;
  logic    res_ready;
  logic    res_push;
  result_t res_new;
  result_t res_head;

  // The window registers can take a write in any cycle.
  assign cfg_ready = 1'b1;

  irpfd_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .high_count   (high_count),
    .period_count (period_count),
    .cls          (front_cls)
  );

  // The event queue's full flag is the capture side's back-pressure.
  irpfd_evt_queue u_evt_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cls (front_cls),
    .full     (full),
    .pop      (evt_pop),
    .valid    (evt_valid),
    .head     (evt_head)
  );

  irpfd_frame_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_cls   (evt_head),
    .evt_pop   (evt_pop),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res_new)
  );

  irpfd_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_res (res_new),
    .ready    (res_ready),
    .pop      (pop),
    .empty    (empty),
    .head     (res_head)
  );

  assign frame_done     = res_head.frame_done;
  assign frame_error    = res_head.frame_error;
  assign addr_code      = res_head.addr_code;
  assign cmd_code       = res_head.cmd_code;
  assign speed_level    = res_head.speed_level;
  assign oscillate_on   = res_head.oscillate_on;
  assign speed_lamp     = res_head.speed_lamp;
  assign oscillate_lamp = res_head.oscillate_lamp;
  assign beep_valid     = res_head.beep_valid;
  assign beep_length    = res_head.beep_length;
  assign beep_repeat    = res_head.beep_repeat;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the IR pulse frame decoder and its fan key handling.
`timescale 1ns / 1ps

module tb_top import irpfd_pkg::*; ();

  // Random captures to send after the directed table, and the hard stop of the run.
  localparam int  RANDOM_ITEMS = 300;
  localparam int  NUM_WIN_REGS = 8;
  localparam int  PRINT_CAP    = 40;
  localparam time RUN_LIMIT    = 8ms;

  typedef enum {ROW_CAPTURE, ROW_FRAME} row_kind_e;
  typedef enum {FR_CLEAN, FR_ABORT, FR_RESTART} frame_style_e;
  typedef enum {
    PRF_DEFAULT, PRF_SHIFTED, PRF_OVERLAP, PRF_INVERTED, PRF_EDGE, PRF_FULL
  } window_profile_e;

  // One row of the directed table: either a single capture with its result typed in,
  // or a whole frame whose results come from the predictor.
  typedef struct {
    row_kind_e             kind;
    logic [15:0]           high;
    logic [15:0]           period;
    logic [FRAME_BITS-1:0] word;
    result_t               want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [15:0]          high_count = '0;
  logic [15:0]          period_count = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 frame_done;
  logic                 frame_error;
  logic [15:0]          addr_code;
  logic [15:0]          cmd_code;
  logic [1:0]           speed_level;
  logic                 oscillate_on;
  logic                 speed_lamp;
  logic                 oscillate_lamp;
  logic                 beep_valid;
  logic [2:0]           beep_length;
  logic [1:0]           beep_repeat;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Predictor state: the window registers as the decoder should hold them, the frame
  // being collected and the fan state.
  win_cfg_t              windows;
  logic                  collecting = 1'b0;
  int                    bits_seen = 0;
  logic [FRAME_BITS-1:0] frame_word = '0;
  logic [15:0]           user_code = '0;
  logic [15:0]           data_code = '0;
  logic [1:0]            fan_level = FAN_OFF;
  logic                  swing_on = 1'b0;
  logic                  level_led = 1'b0;
  logic                  swing_led = 1'b0;

  result_t pending_results[$];
  int      sent = 0;
  int      mismatches = 0;
  bit      steady = 1'b0;

  ir_pulse_frame_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .high_count     (high_count),
    .period_count   (period_count),
    .empty          (empty),
    .pop            (pop),
    .frame_done     (frame_done),
    .frame_error    (frame_error),
    .addr_code      (addr_code),
    .cmd_code       (cmd_code),
    .speed_level    (speed_level),
    .oscillate_on   (oscillate_on),
    .speed_lamp     (speed_lamp),
    .oscillate_lamp (oscillate_lamp),
    .beep_valid     (beep_valid),
    .beep_length    (beep_length),
    .beep_repeat    (beep_repeat),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop: a hang anywhere in the handshakes ends the run here as a failure.
  initial begin
    #RUN_LIMIT;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic in_span(input logic [15:0] v, input logic [15:0] lo,
                                   input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Works out the result of one accepted capture and advances the predictor state.
  // The lead test comes first, so a capture that also fits a bit window starts a frame;
  // a high time inside both bit windows is read as a one.
  function automatic result_t decode_capture(input logic [15:0] h, input logic [15:0] p);
    result_t     r;
    logic [15:0] low_time;
    logic        is_one;
    logic        is_zero;
    r = '0;
    low_time = p - h;
    is_one = in_span(h, windows.one_min, windows.one_max);
    is_zero = in_span(h, windows.zero_min, windows.zero_max);
    if (in_span(h, windows.lead_high_min, windows.lead_high_max) &&
        in_span(low_time, windows.lead_low_min, windows.lead_low_max)) begin
      collecting = 1'b1;
      bits_seen = 0;
      frame_word = '0;
    end else if (collecting) begin
      if (is_one || is_zero) begin
        frame_word[FRAME_BITS-1-bits_seen] = is_one;
        bits_seen++;
        if (bits_seen == FRAME_BITS) begin
          collecting = 1'b0;
          data_code = frame_word[CODE_SPLIT-1:0];
          user_code = 16'(frame_word >> CODE_SPLIT);
          r.frame_done = 1'b1;
          if (user_code == USER_FAN) begin
            case (data_code)
              KEY_POWER: begin
                r.beep_valid = 1'b1;
                r.beep_repeat = REP_ONE;
                if (fan_level == FAN_OFF) begin
                  fan_level = FAN_MIN;
                  r.beep_length = BEEP_SHORT;
                  level_led = 1'b1;
                end else begin
                  // Switching off also drops oscillation and both lamps.
                  fan_level = FAN_OFF;
                  r.beep_length = BEEP_LONG;
                  level_led = 1'b0;
                  swing_on = 1'b0;
                  swing_led = 1'b0;
                end
              end
              KEY_SWING: begin
                if (fan_level != FAN_OFF) begin
                  swing_on = !swing_on;
                  swing_led = swing_on;
                  r.beep_valid = 1'b1;
                  r.beep_length = BEEP_SHORT;
                  r.beep_repeat = swing_on ? REP_ONE : REP_TWO;
                end
              end
              KEY_UP, KEY_DOWN: begin
                // The level saturates at both ends but the beep is still given.
                if (fan_level != FAN_OFF) begin
                  if (data_code == KEY_UP && fan_level != FAN_MAX) fan_level++;
                  if (data_code == KEY_DOWN && fan_level > FAN_MIN) fan_level--;
                  r.beep_valid = 1'b1;
                  r.beep_length = BEEP_SHORT;
                  r.beep_repeat = REP_ONE;
                  level_led = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        collecting = 1'b0;
        r.frame_error = 1'b1;
      end
    end
    r.addr_code = user_code;
    r.cmd_code = data_code;
    r.speed_level = fan_level;
    r.oscillate_on = swing_on;
    r.speed_lamp = level_led;
    r.oscillate_lamp = swing_led;
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // Most capture requests follow each other closely; a few wait a long while.
  function automatic int next_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Edge values of a window come up often; an inverted window gives any value.
  function automatic logic [15:0] pick_between(input logic [15:0] lo, input logic [15:0] hi);
    int unsigned r;
    r = $urandom_range(3, 0);
    if (lo > hi) return 16'($urandom);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Drives one capture request, waits until it is taken and queues what it must yield.
  // Push is left high afterwards, so back-to-back requests never drop it for a cycle.
  task automatic send_capture(input logic [15:0] h, input logic [15:0] p, input bit typed,
                              input result_t want);
    int      gap;
    result_t predicted;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    high_count <= h;
    period_count <= p;
    do @(posedge clk); while (full);
    predicted = decode_capture(h, p);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic send_lead();
    logic [15:0] h;
    h = pick_between(windows.lead_high_min, windows.lead_high_max);
    send_capture(h, h + pick_between(windows.lead_low_min, windows.lead_low_max),
                 1'b0, '0);
  endtask

  // A bit capture; now and then its low time also fits the lead window, so that a
  // high time shared by a bit window and the lead window is tried as a lead.
  task automatic send_bit(input logic b);
    logic [15:0] h;
    logic [15:0] low_time;
    h = b ? pick_between(windows.one_min, windows.one_max)
          : pick_between(windows.zero_min, windows.zero_max);
    low_time = ($urandom_range(7, 0) == 0)
               ? pick_between(windows.lead_low_min, windows.lead_low_max)
               : 16'($urandom);
    send_capture(h, h + low_time, 1'b0, '0);
  endtask

  task automatic send_bad();
    logic [15:0] h;
    h = 16'($urandom);
    repeat (8) begin
      if (in_span(h, windows.one_min, windows.one_max) ||
          in_span(h, windows.zero_min, windows.zero_max)) h = 16'($urandom);
    end
    send_capture(h, 16'($urandom), 1'b0, '0);
  endtask

  // A lead followed by the frame's bits, most significant first. An aborted frame
  // stops at a random bit with an invalid time; a restarted one gets a fresh lead
  // part way through and is then sent in full.
  task automatic send_frame(input logic [FRAME_BITS-1:0] word, input frame_style_e style);
    int pos;
    int cut;
    pos = 0;
    cut = $urandom_range(FRAME_BITS - 1, 0);
    send_lead();
    while (pos < FRAME_BITS) begin
      if (pos == cut && style == FR_ABORT) begin
        send_bad();
        return;
      end
      if (pos == cut && style == FR_RESTART) begin
        send_lead();
        pos = 0;
        style = FR_CLEAN;
      end
      send_bit(word[FRAME_BITS-1-pos]);
      pos++;
    end
  endtask

  // Lowers push and waits until every queued result has been popped, which leaves the
  // decoder idle since each capture yields exactly one result.
  task automatic drain();
    @(negedge clk) push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEAD_HIGH_MIN: windows.lead_high_min = val;
      REG_LEAD_HIGH_MAX: windows.lead_high_max = val;
      REG_LEAD_LOW_MIN:  windows.lead_low_min = val;
      REG_LEAD_LOW_MAX:  windows.lead_low_max = val;
      REG_ONE_MIN:       windows.one_min = val;
      REG_ONE_MAX:       windows.one_max = val;
      REG_ZERO_MIN:      windows.zero_min = val;
      REG_ZERO_MAX:      windows.zero_max = val;
      default: ;
    endcase
  endtask

  // Writes the whole register set, sometimes after a write to an index past the map,
  // which the decoder must ignore. Valid stays high across the burst.
  task automatic load_windows(input win_cfg_t w);
    if ($urandom_range(9, 0) < 4)
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, NUM_WIN_REGS)),
                16'($urandom));
    write_reg(REG_LEAD_HIGH_MIN, w.lead_high_min);
    write_reg(REG_LEAD_HIGH_MAX, w.lead_high_max);
    write_reg(REG_LEAD_LOW_MIN, w.lead_low_min);
    write_reg(REG_LEAD_LOW_MAX, w.lead_low_max);
    write_reg(REG_ONE_MIN, w.one_min);
    write_reg(REG_ONE_MAX, w.one_max);
    write_reg(REG_ZERO_MIN, w.zero_min);
    write_reg(REG_ZERO_MAX, w.zero_max);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic stim_row_t cap_row(input logic [15:0] h, input logic [15:0] p,
                                        input result_t want);
    stim_row_t row;
    row.kind = ROW_CAPTURE;
    row.high = h;
    row.period = p;
    row.word = '0;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t frame_row(input logic [FRAME_BITS-1:0] word);
    stim_row_t row;
    row.kind = ROW_FRAME;
    row.high = '0;
    row.period = '0;
    row.word = word;
    row.want = '0;
    return row;
  endfunction

  // The result side pops in runs of mixed length, broken by stalls that are mostly
  // short; now and then a long run with no stall at all lets the queues run dry.
  initial begin : pop_control
    int unsigned r;
    int          run;
    int          stall;
    forever begin
      r = $urandom_range(99, 0);
      run = (r < 70) ? $urandom_range(8, 1)
          : (r < 90) ? $urandom_range(100, 20) : $urandom_range(400, 200);
      repeat (run) @(negedge clk) pop <= 1'b1;
      r = $urandom_range(99, 0);
      stall = (r < 60) ? $urandom_range(3, 1)
            : (r < 90) ? $urandom_range(12, 4) : $urandom_range(80, 30);
      repeat (stall) @(negedge clk) pop <= 1'b0;
    end
  end

  // Every popped result is held against the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("result popped with no capture waiting for it");
      end else begin
        want = pending_results.pop_front();
        check_field("frame_done", frame_done, want.frame_done);
        check_field("frame_error", frame_error, want.frame_error);
        check_field("addr_code", addr_code, want.addr_code);
        check_field("cmd_code", cmd_code, want.cmd_code);
        check_field("speed_level", speed_level, want.speed_level);
        check_field("oscillate_on", oscillate_on, want.oscillate_on);
        check_field("speed_lamp", speed_lamp, want.speed_lamp);
        check_field("oscillate_lamp", oscillate_lamp, want.oscillate_lamp);
        check_field("beep_valid", beep_valid, want.beep_valid);
        check_field("beep_length", beep_length, want.beep_length);
        check_field("beep_repeat", beep_repeat, want.beep_repeat);
      end
    end
  end

  initial begin : stimulus
    stim_row_t             plan[$];
    result_t               quiet;
    result_t               aborted;
    win_cfg_t              w;
    window_profile_e       profile;
    frame_style_e          style;
    logic [FRAME_BITS-1:0] word;
    logic [15:0]           key;
    logic [15:0]           base;
    int unsigned           r;
    int                    phase;
    int                    first_random;

    quiet = '0;
    aborted = '0;
    aborted.frame_error = 1'b1;
    windows = '{RST_LEAD_HIGH_MIN, RST_LEAD_HIGH_MAX, RST_LEAD_LOW_MIN, RST_LEAD_LOW_MAX,
                RST_ONE_MIN, RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX};

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed table, run on the reset windows. The single captures come first, while
    // the fan is still off, so each of their results is plain to see: everything zero,
    // or just frame_error where a bit time is invalid.
    plan.push_back(cap_row(16'h0000, 16'h0000, quiet));     // idle, field minimums
    plan.push_back(cap_row(16'hffff, 16'hffff, quiet));     // idle, field maximums
    plan.push_back(cap_row(16'hffff, 16'h0000, quiet));     // low time wraps round
    plan.push_back(cap_row(16'h0000, 16'hffff, quiet));
    plan.push_back(cap_row(16'd11999, 16'd13499, quiet));   // high just short of lead
    plan.push_back(cap_row(16'd12000, 16'd13500, quiet));   // lead at lower edges
    plan.push_back(cap_row(16'd800, 16'd2000, quiet));      // zero at its lower edge
    plan.push_back(cap_row(16'd2600, 16'd5000, quiet));     // one at its upper edge
    plan.push_back(cap_row(16'd15000, 16'd17100, quiet));   // lead mid-frame restarts
    plan.push_back(cap_row(16'd1401, 16'd3000, aborted));   // gap between bit windows
    plan.push_back(cap_row(16'd2000, 16'd3000, quiet));     // bit time while idle
    plan.push_back(cap_row(16'd12000, 16'd13499, quiet));   // low time short of lead
    plan.push_back(cap_row(16'd15001, 16'd17101, quiet));   // high just past lead
    plan.push_back(cap_row(16'd12000, 16'd13500, quiet));
    plan.push_back(cap_row(16'd799, 16'd900, aborted));     // just under the zero window
    // Whole frames walk the fan through its keys; their results come from the predictor.
    plan.push_back(frame_row({USER_FAN, KEY_SWING}));       // keys while off do nothing
    plan.push_back(frame_row({USER_FAN, KEY_UP}));
    plan.push_back(frame_row({USER_FAN, KEY_DOWN}));
    plan.push_back(frame_row({USER_FAN, KEY_POWER}));       // on at the lowest level
    plan.push_back(frame_row({USER_FAN, KEY_DOWN}));        // already at the lowest
    plan.push_back(frame_row({USER_FAN, KEY_UP}));
    plan.push_back(frame_row({USER_FAN, KEY_UP}));
    plan.push_back(frame_row({USER_FAN, KEY_UP}));          // already at the top
    plan.push_back(frame_row({USER_FAN, KEY_SWING}));
    plan.push_back(frame_row({USER_FAN, KEY_SWING}));
    plan.push_back(frame_row({USER_FAN, KEY_SWING}));
    plan.push_back(frame_row({USER_FAN, KEY_POWER}));       // off clears oscillation
    plan.push_back(frame_row({16'h1234, KEY_POWER}));       // foreign user code
    plan.push_back(frame_row({USER_FAN, 16'h0000}));        // unknown data code
    plan.push_back(frame_row('1));
    plan.push_back(frame_row('0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_FRAME) send_frame(plan[i].word, FR_CLEAN);
      else send_capture(plan[i].high, plan[i].period, 1'b1, plan[i].want);
    end
    drain();

    // Random part, in phases. Each phase loads a window set while the decoder is idle:
    // the first phases take every kind of set once, later ones pick at random. Well
    // formed frames with random content make up most of the traffic, mixed with stray
    // captures, aborted frames and frames restarted by a second lead.
    first_random = sent;
    phase = 0;
    while (phase < 6 || sent - first_random < RANDOM_ITEMS) begin
      if (phase < 6) begin
        profile = window_profile_e'(phase);
      end else begin
        r = $urandom_range(99, 0);
        profile = (r < 35) ? PRF_DEFAULT : (r < 65) ? PRF_SHIFTED
                : (r < 80) ? PRF_OVERLAP : (r < 90) ? PRF_INVERTED
                : (r < 96) ? PRF_EDGE : PRF_FULL;
      end
      steady = ($urandom_range(3, 0) == 0);
      w = '{RST_LEAD_HIGH_MIN, RST_LEAD_HIGH_MAX, RST_LEAD_LOW_MIN, RST_LEAD_LOW_MAX,
            RST_ONE_MIN, RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX};
      case (profile)
        PRF_SHIFTED: begin
          // Disjoint windows at random places; a width of zero gives a single value,
          // and the lead low window may sit high enough for the low time to wrap.
          w.zero_min = 16'($urandom_range(3000, 0));
          w.zero_max = w.zero_min + 16'($urandom_range(1500, 0));
          w.one_min = w.zero_max + 16'($urandom_range(2000, 1));
          w.one_max = w.one_min + 16'($urandom_range(1500, 0));
          w.lead_high_min = w.one_max + 16'($urandom_range(5000, 1));
          w.lead_high_max = w.lead_high_min + 16'($urandom_range(4000, 0));
          w.lead_low_min = 16'($urandom_range(60000, 0));
          w.lead_low_max = w.lead_low_min + 16'($urandom_range(3000, 0));
        end
        PRF_OVERLAP: begin
          // The bit windows overlap each other, and the lead high window overlaps both.
          base = 16'($urandom_range(20000, 0));
          w.one_min = base + 16'd1000;
          w.one_max = base + 16'd3000;
          w.zero_min = base + 16'd2000;
          w.zero_max = base + 16'd4000;
          w.lead_high_min = base + 16'd2500;
          w.lead_high_max = base + 16'd5000;
          w.lead_low_min = 16'($urandom_range(30000, 0));
          w.lead_low_max = w.lead_low_min + 16'd200;
        end
        PRF_INVERTED: begin
          // Minimum above maximum: that window must never match.
          r = $urandom_range(3, 0);
          if (r != 1) {w.one_min, w.one_max} = {w.one_max, w.one_min};
          if (r != 0) {w.zero_min, w.zero_max} = {w.zero_max, w.zero_min};
          if (r == 3) {w.lead_high_min, w.lead_high_max} = {w.lead_high_max, w.lead_high_min};
        end
        PRF_EDGE: begin
          w.lead_high_min = 16'hffff;
          w.lead_high_max = 16'hffff;
          w.lead_low_min = 16'hffff;
          w.lead_low_max = 16'hffff;
          w.one_min = 16'hffff;
          w.one_max = 16'hffff;
          w.zero_min = 16'h0000;
          w.zero_max = 16'h0000;
        end
        PRF_FULL: begin
          // Every window spans the whole range, so every capture reads as a lead.
          w = '{16'h0000, 16'hffff, 16'h0000, 16'hffff,
                16'h0000, 16'hffff, 16'h0000, 16'hffff};
        end
        default: ;
      endcase
      load_windows(w);

      if (profile == PRF_FULL) begin
        repeat (12) send_capture(16'($urandom), 16'($urandom), 1'b0, '0);
      end else begin
        repeat ($urandom_range(2, 1)) begin
          if ($urandom_range(2, 0) == 0)
            repeat ($urandom_range(2, 1))
              send_capture(16'($urandom), 16'($urandom), 1'b0, '0);
          case ($urandom_range(3, 0))
            0:       key = KEY_POWER;
            1:       key = KEY_SWING;
            2:       key = KEY_UP;
            default: key = KEY_DOWN;
          endcase
          r = $urandom_range(99, 0);
          if (r < 70)      word = {USER_FAN, key};
          else if (r < 80) word = {USER_FAN, 16'($urandom)};
          else if (r < 90) word = {16'($urandom), key};
          else             word = FRAME_BITS'($urandom);
          r = $urandom_range(9, 0);
          style = (r == 0) ? FR_ABORT : (r == 1) ? FR_RESTART : FR_CLEAN;
          send_frame(word, style);
        end
      end
      drain();
      phase++;
    end

    // Every result is in; a few more cycles catch any result the decoder adds of its own.
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/irpfd_pkg.sv
src/irpfd_classify.sv
src/irpfd_evt_queue.sv
src/irpfd_result_queue.sv
src/irpfd_frame_engine.sv
src/ir_pulse_frame_decoder.sv
tb/sv/tb_top.sv
